// ----- sv/nmea_pkg.sv -----
// ----------------------------------------------------------------------------
// nmea_pkg: shared types and constants for the NMEA sentence framer
// Character codes, status codes and the result word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmea_pkg;

  // Framing and trailer characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;

  // Sentence type letters (address characters three to five)
  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_RMC = 24'h524D43;
  localparam logic [23:0] TYPE_GLL = 24'h474C4C;

  // Line status codes
  localparam logic [2:0] ST_NO_CHECKSUM  = 3'd0;
  localparam logic [2:0] ST_BAD_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_IGNORED      = 3'd2;
  localparam logic [2:0] ST_GGA          = 3'd3;
  localparam logic [2:0] ST_RMC          = 3'd4;
  localparam logic [2:0] ST_GLL          = 3'd5;

  // One result word
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  talker_first;
    logic [7:0]  talker_second;
    logic [7:0]  line_length;
    logic [31:0] noise_total;
    logic [31:0] overlong_total;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/nmea_sentence_framer_checker_unit.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_unit: NMEA 0183 line framer and checksum check
// Frames '$'..CR/LF lines, checks trailer and XOR, classifies the address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one serial byte per word on byte_in, in_valid/in_ready.
//   Output channel: one word per finished line (status, talker letters,
//   line length, noise and overlong counters), out_valid/out_ready.
//   Bytes that finish no line produce no output word.
// Timing:
//   One byte is taken every cycle while in_ready is high. All line state
//   (flags, XOR, address, counters) updates in the cycle the byte is
//   accepted; the result word of a CR or LF is registered into the output
//   register, or into the skid register when the output register stays occupied.
// Stall:
//   A two-word output buffer (output register plus skid register) holds
//   results while the receiver stalls; in_ready drops only when both are
//   full, and rises again as soon as the receiver takes a word.
// Reset:
//   rst (synchronous) clears the line state, both counters and the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer_checker_unit #(
  parameter int MAX_LINE_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [7:0]       talker_first,
  output logic [7:0]       talker_second,
  output logic [7:0]       line_length,
  output logic [31:0]      noise_total,
  output logic [31:0]      overlong_total
);

  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  // Saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Hex digit decode: valid flag in bit 4, value in bits 3:0
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Line state registers
  logic          in_line, in_line_next;
  logic [LW-1:0] line_count, line_count_next;
  logic [7:0]    running_xor, running_xor_next;
  logic [7:0]    xor_before_star, xor_before_star_next;
  logic          star_seen, star_seen_next;
  logic [1:0]    after_star_count, after_star_count_next;
  logic [3:0]    hex_high, hex_high_next;
  logic [3:0]    hex_low, hex_low_next;
  logic          trailer_broken, trailer_broken_next;
  logic          comma_seen, comma_seen_next;
  logic [7:0]    address_chars [5];
  logic [7:0]    address_chars_next [5];
  logic [2:0]    address_length, address_length_next;
  logic          address_upper, address_upper_next;
  logic          address_snapshot, address_snapshot_next;
  logic [31:0]   noise_count, noise_count_next;
  logic [31:0]   overlong_count, overlong_count_next;

  // Output buffer
  nmea_pkg::result_t slot0, slot1, result_word;
  logic              v0, v1;
  logic              emit;

  logic          take;
  logic [7:0]    c;
  logic [4:0]    hx;
  logic [LW-1:0] lc_inc;
  logic [2:0]    judged;
  logic          is_term;

  assign in_ready = !v1;
  assign take     = in_valid && in_ready;
  assign c        = byte_in;
  assign hx       = hex_digit(c);
  assign lc_inc   = line_count + 1'b1;
  assign is_term  = (c == nmea_pkg::CHAR_CR) || (c == nmea_pkg::CHAR_LF);

  // Judge the line held in the state registers
  always_comb begin
    if (!star_seen || after_star_count < 2'd2 || trailer_broken) begin
      judged = nmea_pkg::ST_NO_CHECKSUM;
    end else if (xor_before_star != {hex_high, hex_low}) begin
      judged = nmea_pkg::ST_BAD_CHECKSUM;
    end else if (!address_snapshot) begin
      judged = nmea_pkg::ST_IGNORED;
    end else if ({address_chars[2], address_chars[3], address_chars[4]}
                 == nmea_pkg::TYPE_GGA) begin
      judged = nmea_pkg::ST_GGA;
    end else if ({address_chars[2], address_chars[3], address_chars[4]}
                 == nmea_pkg::TYPE_RMC) begin
      judged = nmea_pkg::ST_RMC;
    end else if ({address_chars[2], address_chars[3], address_chars[4]}
                 == nmea_pkg::TYPE_GLL) begin
      judged = nmea_pkg::ST_GLL;
    end else begin
      judged = nmea_pkg::ST_IGNORED;
    end
  end

  // Result word for a terminated line
  always_comb begin
    result_word.status         = judged;
    result_word.talker_first   = (judged >= nmea_pkg::ST_GGA) ? address_chars[0] : 8'd0;
    result_word.talker_second  = (judged >= nmea_pkg::ST_GGA) ? address_chars[1] : 8'd0;
    result_word.line_length    = (32'(line_count) > 32'd255) ? 8'd255 : 8'(line_count);
    result_word.noise_total    = noise_count;
    result_word.overlong_total = overlong_count;
  end

  // Per-byte state update
  always_comb begin
    in_line_next          = in_line;
    line_count_next       = line_count;
    running_xor_next      = running_xor;
    xor_before_star_next  = xor_before_star;
    star_seen_next        = star_seen;
    after_star_count_next = after_star_count;
    hex_high_next         = hex_high;
    hex_low_next          = hex_low;
    trailer_broken_next   = trailer_broken;
    comma_seen_next       = comma_seen;
    for (int i = 0; i < 5; i++) address_chars_next[i] = address_chars[i];
    address_length_next   = address_length;
    address_upper_next    = address_upper;
    address_snapshot_next = address_snapshot;
    noise_count_next      = noise_count;
    overlong_count_next   = overlong_count;
    emit                  = 1'b0;

    if (take) begin
      if (!in_line || c == nmea_pkg::CHAR_DOLLAR) begin
        if (c == nmea_pkg::CHAR_DOLLAR) begin
          // open (or restart) a line; restart dumps the old bytes as noise
          if (in_line) noise_count_next = sat_add(noise_count, 32'(line_count));
          in_line_next          = 1'b1;
          line_count_next       = LW'(1);
          running_xor_next      = 8'd0;
          xor_before_star_next  = 8'd0;
          star_seen_next        = 1'b0;
          after_star_count_next = 2'd0;
          hex_high_next         = 4'd0;
          hex_low_next          = 4'd0;
          trailer_broken_next   = 1'b0;
          comma_seen_next       = 1'b0;
          for (int i = 0; i < 5; i++) address_chars_next[i] = 8'd0;
          address_length_next   = 3'd0;
          address_upper_next    = 1'b1;
          address_snapshot_next = 1'b0;
        end else if (!is_term) begin
          noise_count_next = sat_add(noise_count, 32'd1);
        end
      end else if (is_term) begin
        // end of line; a lone dollar is noise
        in_line_next = 1'b0;
        if (line_count <= LW'(1)) noise_count_next = sat_add(noise_count, 32'd1);
        else emit = 1'b1;
      end else begin
        // body byte: trailer tracking
        if (c == nmea_pkg::CHAR_STAR) begin
          xor_before_star_next  = running_xor;
          star_seen_next        = 1'b1;
          after_star_count_next = 2'd0;
          trailer_broken_next   = 1'b0;
          address_snapshot_next = (address_length == 3'd5) && address_upper;
        end else if (star_seen) begin
          unique case (after_star_count)
            2'd0: begin
              if (!hx[4]) trailer_broken_next = 1'b1;
              else hex_high_next = hx[3:0];
            end
            2'd1: begin
              if (!hx[4]) trailer_broken_next = 1'b1;
              else hex_low_next = hx[3:0];
            end
            default: begin
              if (c != nmea_pkg::CHAR_SPACE && c != nmea_pkg::CHAR_TAB &&
                  c != nmea_pkg::CHAR_NUL) trailer_broken_next = 1'b1;
            end
          endcase
          if (after_star_count != 2'd3) after_star_count_next = after_star_count + 2'd1;
        end
        running_xor_next = running_xor ^ c;
        // address capture up to the first comma
        if (!comma_seen) begin
          if (c == nmea_pkg::CHAR_COMMA) begin
            comma_seen_next = 1'b1;
          end else begin
            for (int i = 0; i < 5; i++) begin
              if (address_length == 3'(i)) address_chars_next[i] = c;
            end
            if (address_length < 3'd6) address_length_next = address_length + 3'd1;
            if (c < nmea_pkg::CHAR_A || c > nmea_pkg::CHAR_Z) address_upper_next = 1'b0;
          end
        end
        // length and overlong drop
        line_count_next = lc_inc;
        if (32'(lc_inc) >= 32'(MAX_LINE_BYTES)) begin
          overlong_count_next = sat_add(overlong_count, 32'd1);
          in_line_next        = 1'b0;
          line_count_next     = '0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_line          <= 1'b0;
      line_count       <= '0;
      running_xor      <= 8'd0;
      xor_before_star  <= 8'd0;
      star_seen        <= 1'b0;
      after_star_count <= 2'd0;
      hex_high         <= 4'd0;
      hex_low          <= 4'd0;
      trailer_broken   <= 1'b0;
      comma_seen       <= 1'b0;
      for (int i = 0; i < 5; i++) address_chars[i] <= 8'd0;
      address_length   <= 3'd0;
      address_upper    <= 1'b1;
      address_snapshot <= 1'b0;
      noise_count      <= 32'd0;
      overlong_count   <= 32'd0;
    end else begin
      in_line          <= in_line_next;
      line_count       <= line_count_next;
      running_xor      <= running_xor_next;
      xor_before_star  <= xor_before_star_next;
      star_seen        <= star_seen_next;
      after_star_count <= after_star_count_next;
      hex_high         <= hex_high_next;
      hex_low          <= hex_low_next;
      trailer_broken   <= trailer_broken_next;
      comma_seen       <= comma_seen_next;
      for (int i = 0; i < 5; i++) address_chars[i] <= address_chars_next[i];
      address_length   <= address_length_next;
      address_upper    <= address_upper_next;
      address_snapshot <= address_snapshot_next;
      noise_count      <= noise_count_next;
      overlong_count   <= overlong_count_next;
    end
  end

  // Two-word output buffer: slot0 drives the ports, slot1 is the skid
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (!v0 || out_ready) begin
      if (v1) begin
        slot0 <= slot1;
        v0    <= 1'b1;
        v1    <= emit;
        if (emit) slot1 <= result_word;
      end else begin
        v0 <= emit;
        if (emit) slot0 <= result_word;
      end
    end else if (emit) begin
      slot1 <= result_word;
      v1    <= 1'b1;
    end
  end

  assign out_valid      = v0;
  assign status         = slot0.status;
  assign talker_first   = slot0.talker_first;
  assign talker_second  = slot0.talker_second;
  assign line_length    = slot0.line_length;
  assign noise_total    = slot0.noise_total;
  assign overlong_total = slot0.overlong_total;

endmodule

`default_nettype wire

// ----- sv/nmea_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_checker: port-level assertions for the NMEA sentence framer
// Watches the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [7:0]  talker_first,
  input wire logic [7:0]  talker_second,
  input wire logic [7:0]  line_length
);

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(line_length))
    else $error("output word changed while stalled");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'd5)
    else $error("status code out of range");

  // A reported line holds at least the dollar and one body byte
  a_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_length >= 8'd2)
    else $error("line length below two");

  // Talker letters only on classified lines
  a_talker: assert property (@(posedge clk) disable iff (rst)
    out_valid && status < 3'd3 |-> talker_first == 8'd0 && talker_second == 8'd0)
    else $error("talker letters on an unclassified line");

endmodule

bind nmea_sentence_framer_checker_unit nmea_checker u_nmea_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .talker_first  (talker_first),
  .talker_second (talker_second),
  .line_length   (line_length)
);

`default_nettype wire
